// File: sv/fdsc_pkg.sv
// Shared types and constants for the fan duty slew controller.
package fdsc_pkg;

    localparam int PERMILLE_W = 10;
    localparam int DIVISOR_W  = 16;
    localparam int CMP_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERMILLE_W-1:0] PERMILLE_FULL = 10'd1000;
    localparam logic [PERMILLE_W-1:0] DUTY_RESET    = 10'd500;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP  = 2'd3;

    localparam logic [14:0] FULL_SCALE_RESET = 15'd14100;
    localparam logic [15:0] PWM_PERIOD_RESET = 16'd600;
    localparam logic [9:0]  DUTY_FLOOR_RESET = 10'd300;
    localparam logic [9:0]  SLEW_STEP_RESET  = 10'd50;

    typedef struct packed {
        logic [14:0]           full_scale;
        logic [15:0]           period;
        logic [PERMILLE_W-1:0] floor_duty;
        logic [PERMILLE_W-1:0] slew;
    } cfg_t;

    // handshake between front end queue and back end
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: sv/fdsc_queue.sv
// Two-entry queue carrying batch maxima from the front end to the back end.
module fdsc_queue
    import fdsc_pkg::*;
#(
    parameter int WIDTH = 15
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  q_ctrl_t          ctrl,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data,
    output q_stat_t          stat
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = ctrl.push && !stat.full;
    assign do_pop     = ctrl.pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/fdsc_front.sv
// Front end: sample magnitude, running batch maximum, hand-off on the last sample.
module fdsc_front
    import fdsc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    sample_last,
    input  q_stat_t                 q_stat,
    output logic                    q_push,
    output logic [SAMPLE_WIDTH-2:0] q_data
);

    localparam int MAG_W = SAMPLE_WIDTH - 1;

    logic [MAG_W-1:0]        run_max_reg;
    logic [MAG_W-1:0]        run_max_next;
    logic [SAMPLE_WIDTH-1:0] neg;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        cand;
    logic                    xfer;

    assign sample_ready = !q_stat.full;
    assign xfer         = sample_valid && sample_ready;

    always_comb
    begin
        neg = -sample;
        if (!sample[SAMPLE_WIDTH-1])
        begin
            mag = sample[MAG_W-1:0];
        end
        else if (neg[SAMPLE_WIDTH-1])
        begin
            // most negative code saturates
            mag = {MAG_W{1'b1}};
        end
        else
        begin
            mag = neg[MAG_W-1:0];
        end
        cand = (mag > run_max_reg) ? mag : run_max_reg;

        run_max_next = run_max_reg;
        if (xfer)
        begin
            run_max_next = sample_last ? '0 : cand;
        end
    end

    assign q_push = xfer && sample_last;
    assign q_data = cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_max_reg <= '0;
        end
        else
        begin
            run_max_reg <= run_max_next;
        end
    end

endmodule

// File: sv/fdsc_div.sv
// Restoring divider for the target duty, one quotient bit per cycle.
module fdsc_div
    import fdsc_pkg::*;
#(
    parameter int DIVIDEND_W = 26
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVIDEND_W-1:0] quot_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W-1:0]  dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign done     = done_reg;
    assign quotient = quot_reg;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[DIVIDEND_W-1]};
        ge        = (trial >= {1'b0, dvs_reg});
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the low bits hold it
            rem_next  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quot_next = {quot_reg[DIVIDEND_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// File: sv/fdsc_back.sv
// Back end: target duty, slew limit, compare value and the output register.
module fdsc_back
    import fdsc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int DIVIDEND_W   = 26
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  q_stat_t                 q_stat,
    output logic                    q_pop,
    input  logic [SAMPLE_WIDTH-2:0] q_data,
    output logic                    res_valid,
    input  logic                    res_ready,
    output logic [PERMILLE_W-1:0]   res_duty,
    output logic [CMP_W-1:0]        res_compare
);

    localparam int MAG_W   = SAMPLE_WIDTH - 1;
    localparam int PROD2_W = CMP_W + PERMILLE_W;

    // floor(x / 1000) as (x * ceil(2^36 / 1000)) >> 36, exact for x below 2^26
    localparam int          RCP_W     = 27;
    localparam int          RCP_SHIFT = 36;
    localparam logic [26:0] RCP_MULT  = 27'd68719477;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_GO1  = 3'd2;
    localparam logic [2:0] ST_DIV1 = 3'd3;
    localparam logic [2:0] ST_SLEW = 3'd4;
    localparam logic [2:0] ST_MUL2 = 3'd5;
    localparam logic [2:0] ST_RCP  = 3'd6;
    localparam logic [2:0] ST_EMIT = 3'd7;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [MAG_W-1:0]      max_reg;
    logic [MAG_W-1:0]      max_next;
    logic [DIVIDEND_W-1:0] prod_reg;
    logic [DIVIDEND_W-1:0] prod_next;
    logic [PERMILLE_W-1:0] target_reg;
    logic [PERMILLE_W-1:0] target_next;
    logic [PERMILLE_W-1:0] duty_reg;
    logic [PERMILLE_W-1:0] duty_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PERMILLE_W-1:0] out_duty_reg;
    logic [PERMILLE_W-1:0] out_duty_next;
    logic [CMP_W-1:0]      out_cmp_reg;
    logic [CMP_W-1:0]      out_cmp_next;

    logic                  div_start;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_q;

    logic [MAG_W+PERMILLE_W-1:0] scaled;
    logic [CMP_W+PERMILLE_W-1:0] period_prod;
    logic [PROD2_W+RCP_W-1:0]    rcp_prod;
    logic [PERMILLE_W-1:0]       floor_c;
    logic [PERMILLE_W-1:0]       clamp_hi;
    logic [PERMILLE_W-1:0]       slew_diff;
    logic                        out_free;

    fdsc_div #(
        .DIVIDEND_W (DIVIDEND_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_start   = (state_reg == ST_GO1);
    assign div_divisor = {1'b0, cfg.full_scale};
    assign q_pop       = (state_reg == ST_IDLE) && !q_stat.empty;
    assign out_free    = !out_valid_reg || res_ready;

    assign res_valid   = out_valid_reg;
    assign res_duty    = out_duty_reg;
    assign res_compare = out_cmp_reg;

    always_comb
    begin
        scaled      = max_reg * PERMILLE_FULL;
        period_prod = cfg.period * (PERMILLE_FULL - duty_reg);
        rcp_prod    = prod_reg[PROD2_W-1:0] * RCP_MULT;
        floor_c     = (cfg.floor_duty > PERMILLE_FULL) ? PERMILLE_FULL : cfg.floor_duty;
        clamp_hi    = (div_q > DIVIDEND_W'(PERMILLE_FULL)) ? PERMILLE_FULL
                                                          : div_q[PERMILLE_W-1:0];
        slew_diff   = (duty_reg > target_reg) ? (duty_reg - target_reg)
                                              : (target_reg - duty_reg);

        state_next     = state_reg;
        max_next       = max_reg;
        prod_next      = prod_reg;
        target_next    = target_reg;
        duty_next      = duty_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_duty_next  = out_duty_reg;
        out_cmp_next   = out_cmp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    max_next   = q_data;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                prod_next = DIVIDEND_W'(scaled);
                if (cfg.full_scale == '0)
                begin
                    // zero full scale saturates the target
                    target_next = PERMILLE_FULL;
                    state_next  = ST_SLEW;
                end
                else
                begin
                    state_next = ST_GO1;
                end
            end
            ST_GO1:
            begin
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    target_next = (clamp_hi < floor_c) ? floor_c : clamp_hi;
                    state_next  = ST_SLEW;
                end
            end
            ST_SLEW:
            begin
                if (slew_diff <= cfg.slew)
                begin
                    duty_next = target_reg;
                end
                else if (duty_reg > target_reg)
                begin
                    duty_next = duty_reg - cfg.slew;
                end
                else
                begin
                    duty_next = duty_reg + cfg.slew;
                end
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                prod_next  = DIVIDEND_W'(period_prod);
                state_next = ST_RCP;
            end
            ST_RCP:
            begin
                // compare value replaces the product
                prod_next  = DIVIDEND_W'(rcp_prod[RCP_SHIFT +: CMP_W]);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_duty_next  = duty_reg;
                    out_cmp_next   = prod_reg[CMP_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        max_reg      <= max_next;
        prod_reg     <= prod_next;
        target_reg   <= target_next;
        out_duty_reg <= out_duty_next;
        out_cmp_reg  <= out_cmp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            duty_reg      <= DUTY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            duty_reg      <= duty_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/fan_duty_slew_controller.sv
// Top level: one sample per cycle in while the queue is not full; per batch the divider runs
// once for the target (skipped with zero full scale), and the back end takes a new batch
// maximum only after its previous result has entered the output register.
// Two batch maxima can queue while the divider is busy.
// Reset: running max cleared, duty set to 500 permille, registers to defaults.
module fan_duty_slew_controller
    import fdsc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // current_sample
    input  logic                             s_tlast,   // last_sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // duty_permille, compare_value
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [CFG_IDX_W-1:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]            cfg_data
);

    localparam int PROD1_W    = SAMPLE_WIDTH - 1 + PERMILLE_W;
    localparam int PROD2_W    = CMP_W + PERMILLE_W;
    localparam int DIVIDEND_W = (PROD1_W > PROD2_W) ? PROD1_W : PROD2_W;

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    q_ctrl_t                 q_ctrl;
    q_stat_t                 q_stat;
    logic [SAMPLE_WIDTH-2:0] q_wr_data;
    logic [SAMPLE_WIDTH-2:0] q_rd_data;
    logic [PERMILLE_W-1:0]   res_duty;
    logic [CMP_W-1:0]        res_compare;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FULL_SCALE: cfg_next.full_scale = cfg_data[14:0];
                REG_PWM_PERIOD: cfg_next.period     = cfg_data;
                REG_DUTY_FLOOR: cfg_next.floor_duty = cfg_data[PERMILLE_W-1:0];
                REG_SLEW_STEP:  cfg_next.slew       = cfg_data[PERMILLE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale <= FULL_SCALE_RESET;
            cfg_reg.period     <= PWM_PERIOD_RESET;
            cfg_reg.floor_duty <= DUTY_FLOOR_RESET;
            cfg_reg.slew       <= SLEW_STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fdsc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (s_tvalid),
        .sample_ready (s_tready),
        .sample       (s_tdata[SAMPLE_WIDTH-1:0]),
        .sample_last  (s_tlast),
        .q_stat       (q_stat),
        .q_push       (q_ctrl.push),
        .q_data       (q_wr_data)
    );

    fdsc_queue #(
        .WIDTH (SAMPLE_WIDTH - 1)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (q_ctrl),
        .wr_data (q_wr_data),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    fdsc_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DIVIDEND_W   (DIVIDEND_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_stat      (q_stat),
        .q_pop       (q_ctrl.pop),
        .q_data      (q_rd_data),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_duty    (res_duty),
        .res_compare (res_compare)
    );

    assign m_tdata = {6'd0, res_compare, res_duty};

endmodule
